// ----- rtl/assert_macros.svh -----
// assertion macros used by the parser rtl
// depends on nothing; included by files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define GUP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gup assertion failed");

// next-cycle implication, disabled during reset
`define GUP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gup assertion failed");

`endif

// ----- rtl/gup_pkg.sv -----
// package for the guid hex text parser: widths, character codes, decoded word type
// depends on nothing
package gup_pkg;

    localparam int CHAR_W       = 8;
    localparam int HALF_W       = 64;
    localparam int COUNT_W      = 6;
    localparam int DIGIT_W      = 4;

    localparam logic [COUNT_W-1:0] TOTAL_DIGITS = 6'd32;
    localparam logic [COUNT_W-1:0] DASH_POS_A   = 6'd8;
    localparam logic [COUNT_W-1:0] DASH_POS_B   = 6'd12;
    localparam logic [COUNT_W-1:0] DASH_POS_C   = 6'd16;
    localparam logic [COUNT_W-1:0] DASH_POS_D   = 6'd20;

    localparam logic [CHAR_W-1:0] DASH_CHAR    = 8'h2D;
    localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'h20;
    localparam logic [CHAR_W-1:0] TAB_CHAR     = 8'h09;
    localparam logic [CHAR_W-1:0] CR_CHAR      = 8'h0D;
    localparam logic [CHAR_W-1:0] ZERO_CHAR    = 8'h30;
    localparam logic [CHAR_W-1:0] NINE_CHAR    = 8'h39;
    localparam logic [CHAR_W-1:0] UPPER_A_CHAR = 8'h41;
    localparam logic [CHAR_W-1:0] UPPER_F_CHAR = 8'h46;
    localparam logic [CHAR_W-1:0] LOWER_A_CHAR = 8'h61;
    localparam logic [CHAR_W-1:0] LOWER_F_CHAR = 8'h66;

    typedef struct packed {
        logic               is_hex;
        logic [DIGIT_W-1:0] hex_val;
        logic               is_dash;
        logic               is_space;
        logic               is_blank;
        logic               first;
        logic               last;
    } char_info_t;

endpackage

// ----- rtl/gup_if.sv -----
// valid/ready word channels of the guid hex text parser
// depends on gup_pkg
interface gup_char_if;
    logic                       valid;
    logic                       ready;
    logic [gup_pkg::CHAR_W-1:0] char_code;
    logic                       first_char;
    logic                       last_char;

    modport source (output valid, char_code, first_char, last_char, input ready);
    modport sink (input valid, char_code, first_char, last_char, output ready);
endinterface

interface gup_guid_if;
    logic                       valid;
    logic                       ready;
    logic [gup_pkg::HALF_W-1:0] guid_high;
    logic [gup_pkg::HALF_W-1:0] guid_low;
    logic                       parse_ok;

    modport source (output valid, guid_high, guid_low, parse_ok, input ready);
    modport sink (input valid, guid_high, guid_low, parse_ok, output ready);
endinterface

// ----- rtl/guid_hex_text_parser_top.sv -----
// path: a word is held in the input register, then its result in the result register
// throughput: one character word per cycle, stalling only while a result waits at the output
// reset (async, active low): start of a text, no result pending, input register empty
// top level of the guid hex text parser
// depends on gup_pkg, gup_if, gup_char_decode, gup_parse_core
module guid_hex_text_parser_top (
    input  logic      clk,
    input  logic      rst_n,
    gup_char_if.sink  chars,
    gup_guid_if.source guid
);
    import gup_pkg::*;

    char_info_t dec_info;
    char_info_t info_reg, info_next;
    logic       in_vld_reg, in_vld_next;
    logic       core_ready;

    gup_char_decode u_decode (
        .char_code  (chars.char_code),
        .first_char (chars.first_char),
        .last_char  (chars.last_char),
        .info       (dec_info)
    );

    assign chars.ready = !in_vld_reg || core_ready;

    always_comb
    begin
        in_vld_next = chars.ready ? chars.valid : in_vld_reg;
        info_next   = (chars.ready && chars.valid) ? dec_info : info_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        info_reg <= info_next;
    end

    gup_parse_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_vld_reg),
        .in_info  (info_reg),
        .in_ready (core_ready),
        .guid     (guid)
    );

endmodule

// ----- rtl/gup_char_decode.sv -----
// character classifier: hex digit value, dash, space, whitespace
// depends on gup_pkg
module gup_char_decode (
    input  logic [gup_pkg::CHAR_W-1:0] char_code,
    input  logic                       first_char,
    input  logic                       last_char,
    output gup_pkg::char_info_t        info
);
    import gup_pkg::*;

    logic is_num;
    logic is_upper;
    logic is_lower;

    always_comb
    begin
        is_num   = (char_code >= ZERO_CHAR) && (char_code <= NINE_CHAR);
        is_upper = (char_code >= UPPER_A_CHAR) && (char_code <= UPPER_F_CHAR);
        is_lower = (char_code >= LOWER_A_CHAR) && (char_code <= LOWER_F_CHAR);

        info.is_hex   = is_num || is_upper || is_lower;
        // letters a..f sit at low nibble 1..6 in both cases
        info.hex_val  = is_num ? char_code[DIGIT_W-1:0]
                               : DIGIT_W'(char_code[DIGIT_W-1:0] + DIGIT_W'(9));
        info.is_dash  = (char_code == DASH_CHAR);
        info.is_space = (char_code == SPACE_CHAR);
        info.is_blank = (char_code == SPACE_CHAR)
                     || ((char_code >= TAB_CHAR) && (char_code <= CR_CHAR));
        info.first    = first_char;
        info.last     = last_char;
    end

endmodule

// ----- rtl/gup_parse_core.sv -----
// parse state, identifier shift register and result register
// depends on gup_pkg, gup_if, assert_macros.svh
`include "assert_macros.svh"

module gup_parse_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  gup_pkg::char_info_t in_info,
    output logic                in_ready,
    gup_guid_if.source          guid
);
    import gup_pkg::*;

    logic [COUNT_W-1:0] count_reg, count_next;
    logic [HALF_W-1:0]  acc_high_reg, acc_high_next;
    logic [HALF_W-1:0]  acc_low_reg, acc_low_next;
    logic               lead_reg, lead_next;
    logic               done_reg, done_next;

    logic               out_vld_reg, out_vld_next;
    logic [HALF_W-1:0]  out_high_reg, out_high_next;
    logic [HALF_W-1:0]  out_low_reg, out_low_next;
    logic               out_ok_reg, out_ok_next;

    logic               fire;
    logic               emit;
    logic               emit_ok;
    logic               dash_ok;
    logic [COUNT_W-1:0] count_cur;
    logic [COUNT_W-1:0] count_inc;
    logic [HALF_W-1:0]  high_cur;
    logic [HALF_W-1:0]  low_cur;
    logic               lead_cur;
    logic               done_cur;

    assign fire     = in_valid && (!out_vld_reg || guid.ready);
    assign in_ready = fire;

    always_comb
    begin
        // first mark restarts the text before this word is looked at
        count_cur = in_info.first ? '0 : count_reg;
        high_cur  = in_info.first ? '0 : acc_high_reg;
        low_cur   = in_info.first ? '0 : acc_low_reg;
        lead_cur  = in_info.first ? 1'b1 : lead_reg;
        done_cur  = in_info.first ? 1'b0 : done_reg;
        count_inc = COUNT_W'(count_cur + COUNT_W'(1));
        dash_ok   = (count_cur == DASH_POS_A) || (count_cur == DASH_POS_B)
                 || (count_cur == DASH_POS_C) || (count_cur == DASH_POS_D);

        count_next    = count_cur;
        acc_high_next = high_cur;
        acc_low_next  = low_cur;
        lead_next     = lead_cur;
        emit          = 1'b0;
        emit_ok       = 1'b0;

        if (done_cur)
        begin
            emit = 1'b0;
        end
        else if (lead_cur && in_info.is_blank)
        begin
            emit = in_info.last;
        end
        else
        begin
            lead_next = 1'b0;
            if (in_info.is_hex)
            begin
                acc_high_next = {high_cur[HALF_W-DIGIT_W-1:0], low_cur[HALF_W-1 -: DIGIT_W]};
                acc_low_next  = {low_cur[HALF_W-DIGIT_W-1:0], in_info.hex_val};
                count_next    = count_inc;
                if (count_inc == TOTAL_DIGITS)
                begin
                    emit    = 1'b1;
                    emit_ok = 1'b1;
                end
                else
                begin
                    emit = in_info.last;
                end
            end
            else if (in_info.is_dash)
            begin
                emit = !dash_ok || in_info.last;
            end
            else if (in_info.is_space)
            begin
                emit = in_info.last;
            end
            else
            begin
                emit = 1'b1;
            end
        end

        done_next = done_cur || emit;

        out_high_next = emit_ok ? acc_high_next : '0;
        out_low_next  = emit_ok ? acc_low_next : '0;
        out_ok_next   = emit_ok;
        out_vld_next  = fire ? emit : (out_vld_reg && !guid.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            acc_high_reg <= '0;
            acc_low_reg  <= '0;
            lead_reg     <= 1'b1;
            done_reg     <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
            if (fire)
            begin
                count_reg    <= count_next;
                acc_high_reg <= acc_high_next;
                acc_low_reg  <= acc_low_next;
                lead_reg     <= lead_next;
                done_reg     <= done_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && emit)
        begin
            out_high_reg <= out_high_next;
            out_low_reg  <= out_low_next;
            out_ok_reg   <= out_ok_next;
        end
    end

    assign guid.valid     = out_vld_reg;
    assign guid.guid_high = out_high_reg;
    assign guid.guid_low  = out_low_reg;
    assign guid.parse_ok  = out_ok_reg;

    `GUP_ASSERT_IMPL(a_fail_zero, clk, rst_n,
        out_vld_reg && !out_ok_reg, (out_high_reg == '0) && (out_low_reg == '0))
    `GUP_ASSERT_NEXT(a_emit_done, clk, rst_n, fire && emit, done_reg)
    `GUP_ASSERT_NEXT(a_ok_count, clk, rst_n, fire && emit_ok, count_reg == TOTAL_DIGITS)
    `GUP_ASSERT_IMPL(a_done_quiet, clk, rst_n, fire && done_reg && !in_info.first, !emit)

endmodule

// ----- verif/testbench.sv -----
// self-checking testbench for guid_hex_text_parser_top: directed table, then random texts
// the driver runs a cycle-free predictor of the parser on every accepted char word
// depends on gup_pkg, gup_if and the rtl of guid_hex_text_parser_top
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import gup_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              first;
        logic              last;
    } char_word_t;

    typedef struct packed {
        logic [HALF_W-1:0] guid_hi;
        logic [HALF_W-1:0] guid_lo;
        logic              ok;
    } guid_word_t;

    typedef enum logic [1:0] {
        EXP_PREDICTED,
        EXP_NONE,
        EXP_GIVEN
    } row_kind_t;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              first;
        logic              last;
        logic [5:0]        reps;
        row_kind_t         kind;
        guid_word_t        given;
    } char_row_t;

    localparam guid_word_t GUID_FAIL = '{64'h0, 64'h0, 1'b0};
    localparam guid_word_t GUID_ALL_F = '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1};
    localparam guid_word_t GUID_ALL_B = '{64'hBBBB_BBBB_BBBB_BBBB, 64'hBBBB_BBBB_BBBB_BBBB, 1'b1};

    localparam int NUM_ROWS = 27;
    localparam char_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        '{"!",          1'b0, 1'b0, 6'd1,  EXP_GIVEN,     GUID_FAIL},
        '{TAB_CHAR,     1'b1, 1'b0, 6'd1,  EXP_NONE,      GUID_FAIL},
        '{CR_CHAR,      1'b0, 1'b1, 6'd1,  EXP_GIVEN,     GUID_FAIL},
        '{LOWER_A_CHAR, 1'b0, 1'b1, 6'd1,  EXP_NONE,      GUID_FAIL},
        '{8'h0B,        1'b1, 1'b0, 6'd1,  EXP_NONE,      GUID_FAIL},
        '{8'h0A,        1'b0, 1'b0, 6'd1,  EXP_NONE,      GUID_FAIL},
        '{8'h0C,        1'b0, 1'b0, 6'd1,  EXP_NONE,      GUID_FAIL},
        '{SPACE_CHAR,   1'b0, 1'b0, 6'd1,  EXP_NONE,      GUID_FAIL},
        '{LOWER_F_CHAR, 1'b0, 1'b1, 6'd32, EXP_GIVEN,     GUID_ALL_F},
        '{ZERO_CHAR,    1'b1, 1'b0, 6'd8,  EXP_PREDICTED, GUID_FAIL},
        '{DASH_CHAR,    1'b0, 1'b0, 6'd3,  EXP_PREDICTED, GUID_FAIL},
        '{NINE_CHAR,    1'b0, 1'b0, 6'd4,  EXP_PREDICTED, GUID_FAIL},
        '{DASH_CHAR,    1'b0, 1'b0, 6'd1,  EXP_PREDICTED, GUID_FAIL},
        '{UPPER_A_CHAR, 1'b0, 1'b0, 6'd4,  EXP_PREDICTED, GUID_FAIL},
        '{SPACE_CHAR,   1'b0, 1'b0, 6'd2,  EXP_PREDICTED, GUID_FAIL},
        '{DASH_CHAR,    1'b0, 1'b0, 6'd1,  EXP_PREDICTED, GUID_FAIL},
        '{UPPER_F_CHAR, 1'b0, 1'b0, 6'd4,  EXP_PREDICTED, GUID_FAIL},
        '{DASH_CHAR,    1'b0, 1'b0, 6'd2,  EXP_PREDICTED, GUID_FAIL},
        '{LOWER_A_CHAR, 1'b0, 1'b0, 6'd11, EXP_PREDICTED, GUID_FAIL},
        '{"5",          1'b0, 1'b1, 6'd1,  EXP_PREDICTED, GUID_FAIL},
        '{"7",          1'b0, 1'b1, 6'd1,  EXP_NONE,      GUID_FAIL},
        '{"1",          1'b1, 1'b0, 6'd3,  EXP_PREDICTED, GUID_FAIL},
        '{DASH_CHAR,    1'b0, 1'b0, 6'd1,  EXP_GIVEN,     GUID_FAIL},
        '{"2",          1'b1, 1'b1, 6'd1,  EXP_GIVEN,     GUID_FAIL},
        '{8'h00,        1'b1, 1'b0, 6'd1,  EXP_GIVEN,     GUID_FAIL},
        '{8'hFF,        1'b1, 1'b1, 6'd1,  EXP_GIVEN,     GUID_FAIL},
        '{"B",          1'b1, 1'b0, 6'd34, EXP_GIVEN,     GUID_ALL_B}
    };

    localparam logic [CHAR_W-1:0] BLANKS [6] = '{TAB_CHAR, 8'h0A, 8'h0B, 8'h0C, CR_CHAR, SPACE_CHAR};

    localparam int RANDOM_CHARS = 1830;
    localparam int CALM_CHARS   = 150;
    localparam int HOLD_AFTER   = 700;
    localparam int HOLD_CYCLES  = 300;

    logic clk;
    logic rst_n;

    gup_char_if chars ();
    gup_guid_if guid ();

    guid_hex_text_parser_top u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .chars (chars),
        .guid  (guid)
    );

    logic [COUNT_W-1:0] digits_seen;
    logic [HALF_W-1:0]  id_high;
    logic [HALF_W-1:0]  id_low;
    bit                 skipping_blanks;
    bit                 text_done;

    guid_word_t expected_guids [$];
    char_word_t text_words [$];
    guid_word_t want_guid;
    int         mismatches;
    int         accepted_chars;
    int         idle_odds;
    bit         calm;
    bit         hold_done;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic report_mismatch(input string field, input logic [HALF_W-1:0] got,
                                   input logic [HALF_W-1:0] want);
        $display("guid mismatch on %s: got %h, want %h at %0t", field, got, want, $realtime);
        mismatches++;
    endtask

    function automatic void restart_text();
        digits_seen     = '0;
        id_high         = '0;
        id_low          = '0;
        skipping_blanks = 1'b1;
        text_done       = 1'b0;
    endfunction

    function automatic bit close_text(input bit ok, output guid_word_t res);
        res.guid_hi = ok ? id_high : '0;
        res.guid_lo = ok ? id_low : '0;
        res.ok      = ok;
        text_done   = 1'b1;
        return 1'b1;
    endfunction

    function automatic bit parse_char(input char_word_t w, output guid_word_t res);
        logic [DIGIT_W-1:0] nib;
        bit                 is_hex;
        res    = '0;
        nib    = '0;
        is_hex = 1'b0;
        if (w.first)
            restart_text();
        if (text_done)
            return 1'b0;
        if (skipping_blanks && (w.code == SPACE_CHAR || (w.code >= TAB_CHAR && w.code <= CR_CHAR)))
        begin
            if (w.last)
                return close_text(1'b0, res);
            return 1'b0;
        end
        skipping_blanks = 1'b0;
        if (w.code >= ZERO_CHAR && w.code <= NINE_CHAR)
        begin
            is_hex = 1'b1;
            nib    = 4'(w.code - ZERO_CHAR);
        end
        else if (w.code >= UPPER_A_CHAR && w.code <= UPPER_F_CHAR)
        begin
            is_hex = 1'b1;
            nib    = 4'(w.code - UPPER_A_CHAR + 8'd10);
        end
        else if (w.code >= LOWER_A_CHAR && w.code <= LOWER_F_CHAR)
        begin
            is_hex = 1'b1;
            nib    = 4'(w.code - LOWER_A_CHAR + 8'd10);
        end
        if (is_hex)
        begin
            {id_high, id_low} = {id_high[HALF_W-5:0], id_low, nib};
            digits_seen = digits_seen + 1'b1;
            if (digits_seen >= TOTAL_DIGITS)
                return close_text(1'b1, res);
        end
        else if (w.code == DASH_CHAR)
        begin
            if (digits_seen != DASH_POS_A && digits_seen != DASH_POS_B &&
                digits_seen != DASH_POS_C && digits_seen != DASH_POS_D)
                return close_text(1'b0, res);
        end
        else if (w.code != SPACE_CHAR)
            return close_text(1'b0, res);
        if (w.last)
            return close_text(1'b0, res);
        return 1'b0;
    endfunction

    task automatic send_char(input char_word_t w, output bit got, output guid_word_t res);
        if (!calm && idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
        begin
            chars.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        chars.valid      <= 1'b1;
        chars.char_code  <= w.code;
        chars.first_char <= w.first;
        chars.last_char  <= w.last;
        @(posedge clk);
        while (!chars.ready)
            @(posedge clk);
        accepted_chars++;
        got = parse_char(w, res);
    endtask

    function automatic char_word_t plain_word(input logic [CHAR_W-1:0] code);
        char_word_t w;
        w.code  = code;
        w.first = 1'b0;
        w.last  = 1'b0;
        return w;
    endfunction

    task automatic build_text();
        int          shape;
        int          cut;
        int          pos;
        logic [3:0]  v;
        char_word_t  w;
        text_words.delete();
        shape = $urandom_range(0, 15);
        if (shape >= 14)
        begin
            repeat ($urandom_range(1, 8))
            begin
                w.code  = 8'($urandom_range(0, 255));
                w.first = 1'($urandom_range(0, 1));
                w.last  = 1'($urandom_range(0, 1));
                text_words.push_back(w);
            end
            return;
        end
        repeat ($urandom_range(0, 3))
            text_words.push_back(plain_word(BLANKS[$urandom_range(0, 5)]));
        for (int k = 1; k <= 32; k++)
        begin
            v = 4'($urandom_range(0, 15));
            if (v < 10)
                text_words.push_back(plain_word(ZERO_CHAR + 8'(v)));
            else
                text_words.push_back(plain_word(($urandom_range(0, 1) ? UPPER_A_CHAR : LOWER_A_CHAR)
                                                + 8'(v) - 8'd10));
            if ((k == 8 || k == 12 || k == 16 || k == 20) && $urandom_range(0, 3) != 0)
                repeat ($urandom_range(1, 2)) text_words.push_back(plain_word(DASH_CHAR));
            else if ($urandom_range(0, 15) == 0)
                text_words.push_back(plain_word(SPACE_CHAR));
        end
        case (shape)
            10, 11:
            begin
                cut = $urandom_range(1, text_words.size() - 1);
                while (text_words.size() > cut)
                    void'(text_words.pop_back());
            end
            12:
            begin
                pos = $urandom_range(0, text_words.size() - 1);
                text_words[pos].code = 8'($urandom_range(0, 255));
            end
            13:
            begin
                pos = $urandom_range(0, text_words.size() - 1);
                text_words.insert(pos, plain_word(DASH_CHAR));
            end
            default:
            begin
            end
        endcase
        text_words[0].first = 1'b1;
        if ($urandom_range(0, 7) != 0)
            text_words[text_words.size() - 1].last = 1'b1;
        if ($urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(1, 3))
            begin
                w.code  = 8'($urandom_range(0, 255));
                w.first = 1'b0;
                w.last  = 1'($urandom_range(0, 1));
                text_words.push_back(w);
            end
        end
    endtask

    initial
    begin
        char_word_t w;
        guid_word_t res;
        bit         got;
        int         random_sent;
        int         texts;
        rst_n            = 1'b0;
        chars.valid      = 1'b0;
        chars.char_code  = '0;
        chars.first_char = 1'b0;
        chars.last_char  = 1'b0;
        mismatches       = 0;
        accepted_chars   = 0;
        idle_odds        = 4;
        calm             = 1'b0;
        random_sent      = 0;
        texts            = 0;
        restart_text();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < NUM_ROWS; r++)
        begin
            for (int n = 0; n < DIRECTED_ROWS[r].reps; n++)
            begin
                w.code  = DIRECTED_ROWS[r].code;
                w.first = DIRECTED_ROWS[r].first && n == 0;
                w.last  = DIRECTED_ROWS[r].last && n == DIRECTED_ROWS[r].reps - 1;
                send_char(w, got, res);
                if (got && DIRECTED_ROWS[r].kind == EXP_PREDICTED)
                    expected_guids.push_back(res);
                else if (got && DIRECTED_ROWS[r].kind == EXP_GIVEN)
                    expected_guids.push_back(DIRECTED_ROWS[r].given);
            end
        end

        while (random_sent < RANDOM_CHARS)
        begin
            if (texts % 8 == 0)
                idle_odds = ($urandom_range(0, 3) == 0) ? 0 : 2 << $urandom_range(0, 2);
            texts++;
            build_text();
            foreach (text_words[i])
            begin
                send_char(text_words[i], got, res);
                if (got)
                    expected_guids.push_back(res);
                random_sent++;
                if (random_sent > RANDOM_CHARS - CALM_CHARS)
                    calm = 1'b1;
            end
        end
        chars.valid <= 1'b0;

        while (expected_guids.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        guid.ready = 1'b0;
        hold_done  = 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!hold_done && accepted_chars >= HOLD_AFTER)
            begin
                guid.ready <= 1'b0;
                hold_done = 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!calm && idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
            begin
                guid.ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            else
            begin
                guid.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && guid.valid && guid.ready)
        begin
            if (expected_guids.size() == 0)
            begin
                report_mismatch("unexpected word", guid.guid_high, '0);
            end
            else
            begin
                want_guid = expected_guids.pop_front();
                if (guid.guid_high !== want_guid.guid_hi)
                    report_mismatch("guid_high", guid.guid_high, want_guid.guid_hi);
                if (guid.guid_low !== want_guid.guid_lo)
                    report_mismatch("guid_low", guid.guid_low, want_guid.guid_lo);
                if (guid.parse_ok !== want_guid.ok)
                    report_mismatch("parse_ok", 64'(guid.parse_ok), 64'(want_guid.ok));
            end
        end
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/gup_pkg.sv
rtl/gup_if.sv
rtl/gup_char_decode.sv
rtl/gup_parse_core.sv
rtl/guid_hex_text_parser_top.sv
verif/testbench.sv
